### hw/rtl/bmft_pkg.sv
package bmft_pkg;

    // default geometry
    localparam int PAGES_PER_BLK_DEF = 4;
    localparam int DATA_BLOCKS_DEF   = 3;
    localparam int TOTAL_BLOCKS_DEF  = 4;

    // fixed field widths
    localparam int SEC_W  = 4;
    localparam int ADDR_W = 4;

    typedef enum logic [1:0] {
        FC_READ      = 2'd0,
        FC_PROG_HOST = 2'd1,
        FC_PROG_COPY = 2'd2,
        FC_ERASE     = 2'd3
    } t_flash_cmd;

    // which address goes out with a command
    typedef enum logic [1:0] {
        AS_PAGE = 2'd0,
        AS_SRC  = 2'd1,
        AS_DST  = 2'd2,
        AS_BLK  = 2'd3
    } t_addr_sel;

    typedef struct packed {
        logic       idle;
        logic       take;
        logic       lat_map;
        logic       lat_row;
        logic       push;
        t_flash_cmd fcmd;
        t_addr_sel  asel;
        logic       last;
        logic       cnt_clr;
        logic       cnt_inc;
        logic       upd_page;
        logic       upd_move;
    } t_dp_cmd;

    typedef struct packed {
        logic req_valid;
        logic op_wr;
        logic in_range;
        logic pg_written;
        logic at_off;
        logic at_end;
        logic out_free;
    } t_dp_sts;

endpackage

### hw/rtl/bmft_if.sv
interface bmft_req_if import bmft_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             operation;
    logic [SEC_W-1:0] logical_sector;

    modport source (output valid, output operation, output logical_sector, input ready);
    modport sink (input valid, input operation, input logical_sector, output ready);
endinterface

interface bmft_cmd_if import bmft_pkg::*; ();
    logic              valid;
    logic              ready;
    t_flash_cmd        flash_command;
    logic [ADDR_W-1:0] flash_address;
    logic              last;

    modport source (output valid, output flash_command, output flash_address, output last,
                    input ready);
    modport sink (input valid, input flash_command, input flash_address, input last,
                  output ready);
endinterface

### hw/rtl/block_mapping_flash_translation.sv
// channel   dir  modport             payload
// i_req     in   bmft_req_if.sink    operation, logical_sector
// o_cmd     out  bmft_cmd_if.source  flash_command, flash_address, last
//
// a request takes three lookup steps (accept, map read, written-row read), then
// one flash command per cycle while the output register is free: one for a read
// or a first write, 2*PAGES_PER_BLK for an overwrite; an out-of-range sector gets none
// the pace is set by the registered read ports of the block map and written-row memories
// reset is synchronous; map and row written flags clear at once, so no clearing pass
// a held command in the output register stalls the sequencer and with it the request
// side; a held final command still lets the next request be taken and looked up
module block_mapping_flash_translation import bmft_pkg::*; #(
    parameter int PAGES_PER_BLK = PAGES_PER_BLK_DEF,
    parameter int DATA_BLOCKS   = DATA_BLOCKS_DEF,
    parameter int TOTAL_BLOCKS  = TOTAL_BLOCKS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bmft_req_if.sink   i_req,
    bmft_cmd_if.source o_cmd
);

    // command and status between sequencer and datapath
    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    // sequencer: lookup, single command, or block copy then erase
    bmft_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (dp_sts),
        .o_cmd   (dp_cmd)
    );

    // datapath: block map, free block, written rows, address forming, output register
    bmft_dp #(
        .PAGES_PER_BLK (PAGES_PER_BLK),
        .DATA_BLOCKS   (DATA_BLOCKS),
        .TOTAL_BLOCKS  (TOTAL_BLOCKS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_out   (o_cmd),
        .i_cmd   (dp_cmd),
        .o_sts   (dp_sts)
    );

endmodule

### hw/rtl/bmft_ctrl.sv
module bmft_ctrl import bmft_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_MAP    = 7'b0000010,
        S_ROW    = 7'b0000100,
        S_SINGLE = 7'b0001000,
        S_CP_RD  = 7'b0010000,
        S_CP_WR  = 7'b0100000,
        S_ERASE  = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.fcmd = FC_READ;
        o_cmd.asel = AS_PAGE;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.idle = 1'b1;
                if (i_sts.req_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = S_MAP;
                end
            end
            S_MAP: begin
                o_cmd.lat_map = 1'b1;
                // sectors past the data blocks are dropped
                n_state = i_sts.in_range ? S_ROW : S_IDLE;
            end
            S_ROW: begin
                o_cmd.lat_row = 1'b1;
                o_cmd.cnt_clr = 1'b1;
                if (i_sts.op_wr && i_sts.pg_written) begin
                    n_state = S_CP_RD;
                end else begin
                    n_state = S_SINGLE;
                end
            end
            S_SINGLE: begin
                o_cmd.fcmd = i_sts.op_wr ? FC_PROG_HOST : FC_READ;
                o_cmd.last = 1'b1;
                if (i_sts.out_free) begin
                    o_cmd.push     = 1'b1;
                    o_cmd.upd_page = i_sts.op_wr;
                    n_state        = S_IDLE;
                end
            end
            S_CP_RD: begin
                if (i_sts.at_off) begin
                    o_cmd.fcmd = FC_PROG_HOST;
                    o_cmd.asel = AS_DST;
                end else begin
                    o_cmd.asel = AS_SRC;
                end
                if (i_sts.out_free) begin
                    o_cmd.push = 1'b1;
                    if (i_sts.at_off) begin
                        o_cmd.cnt_inc = 1'b1;
                        n_state       = i_sts.at_end ? S_ERASE : S_CP_RD;
                    end else begin
                        n_state = S_CP_WR;
                    end
                end
            end
            S_CP_WR: begin
                o_cmd.fcmd = FC_PROG_COPY;
                o_cmd.asel = AS_DST;
                if (i_sts.out_free) begin
                    o_cmd.push    = 1'b1;
                    o_cmd.cnt_inc = 1'b1;
                    n_state       = i_sts.at_end ? S_ERASE : S_CP_RD;
                end
            end
            S_ERASE: begin
                o_cmd.fcmd = FC_ERASE;
                o_cmd.asel = AS_BLK;
                o_cmd.last = 1'b1;
                if (i_sts.out_free) begin
                    o_cmd.push     = 1'b1;
                    o_cmd.upd_move = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### hw/rtl/bmft_dp.sv
module bmft_dp import bmft_pkg::*; #(
    parameter int PAGES_PER_BLK = PAGES_PER_BLK_DEF,
    parameter int DATA_BLOCKS   = DATA_BLOCKS_DEF,
    parameter int TOTAL_BLOCKS  = TOTAL_BLOCKS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bmft_req_if.sink   i_req,
    bmft_cmd_if.source o_out,
    input  t_dp_cmd    i_cmd,
    output t_dp_sts    o_sts
);

    localparam int SEC_N = 1 << SEC_W;
    localparam int MI_W  = (DATA_BLOCKS > 1) ? $clog2(DATA_BLOCKS) : 1;
    localparam int BK_W  = $clog2(TOTAL_BLOCKS);
    localparam int OF_W  = $clog2(PAGES_PER_BLK);
    localparam int PG_W  = $clog2(TOTAL_BLOCKS * PAGES_PER_BLK);

    function automatic logic [PG_W-1:0] page_of(input logic [BK_W-1:0] blk,
                                                 input logic [OF_W-1:0] pg);
        page_of = PG_W'(blk) * PG_W'(PAGES_PER_BLK) + PG_W'(pg);
    endfunction

    // request fields
    logic            r_op;
    logic [MI_W-1:0] r_lblk;
    logic [OF_W-1:0] r_off;
    logic            r_rng;
    logic [MI_W-1:0] lblk_in;
    logic [OF_W-1:0] off_in;
    logic            rng_in;

    // block map: memory plus per-entry written flag, unwritten reads as identity
    logic [BK_W-1:0]        map_mem [DATA_BLOCKS];
    logic [BK_W-1:0]        r_map_rd;
    logic [DATA_BLOCKS-1:0] r_map_vld;
    logic [BK_W-1:0]        pblk_now;
    logic [BK_W-1:0]        r_pblk;
    logic [BK_W-1:0]        r_fblk;

    // page-written rows, one row per physical block
    logic [PAGES_PER_BLK-1:0] row_mem [TOTAL_BLOCKS];
    logic [PAGES_PER_BLK-1:0] r_row_rd;
    logic [TOTAL_BLOCKS-1:0]  r_row_vld;
    logic [TOTAL_BLOCKS-1:0]  n_row_vld;
    logic [PAGES_PER_BLK-1:0] row_now;
    logic [PAGES_PER_BLK-1:0] r_row;
    logic [PAGES_PER_BLK-1:0] row_wdata;
    logic                     row_we;
    logic [BK_W-1:0]          row_waddr;

    logic [OF_W-1:0] r_cnt;

    // output register
    logic              r_out_vld;
    t_flash_cmd        r_out_cmd;
    logic [ADDR_W-1:0] r_out_addr;
    logic              r_out_last;
    logic [ADDR_W-1:0] addr_sel;

    // sector split as a small constant table
    always_comb begin
        lblk_in = '0;
        off_in  = '0;
        rng_in  = 1'b0;
        for (int s = 0; s < SEC_N; s++) begin
            if (i_req.logical_sector == SEC_W'(s)) begin
                rng_in = (s / PAGES_PER_BLK) < DATA_BLOCKS;
                off_in = OF_W'(s % PAGES_PER_BLK);
                if ((s / PAGES_PER_BLK) < DATA_BLOCKS) begin
                    lblk_in = MI_W'(s / PAGES_PER_BLK);
                end
            end
        end
    end

    assign i_req.ready = i_cmd.idle;

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_op   <= i_req.operation;
            r_lblk <= lblk_in;
            r_off  <= off_in;
            r_rng  <= rng_in;
        end
    end

    // map memory
    always_ff @(posedge i_clk) begin
        r_map_rd <= map_mem[lblk_in];
        if (i_cmd.upd_move) begin
            map_mem[r_lblk] <= r_fblk;
        end
    end

    assign pblk_now = r_map_vld[r_lblk] ? r_map_rd : BK_W'(r_lblk);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_vld <= '0;
            r_fblk    <= BK_W'(DATA_BLOCKS);
        end else if (i_cmd.upd_move) begin
            r_map_vld[r_lblk] <= 1'b1;
            r_fblk            <= r_pblk;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.lat_map) begin
            r_pblk <= pblk_now;
        end
    end

    // row memory
    assign row_we    = i_cmd.upd_page | i_cmd.upd_move;
    assign row_waddr = i_cmd.upd_move ? r_fblk : r_pblk;
    assign row_wdata = r_row | (PAGES_PER_BLK'(1) << r_off);

    always_ff @(posedge i_clk) begin
        r_row_rd <= row_mem[pblk_now];
        if (row_we) begin
            row_mem[row_waddr] <= row_wdata;
        end
    end

    assign row_now = r_row_vld[r_pblk] ? r_row_rd : '0;

    // new row marked written, old block dropped after a move
    always_comb begin
        n_row_vld = r_row_vld;
        if (row_we) begin
            n_row_vld[row_waddr] = 1'b1;
        end
        if (i_cmd.upd_move) begin
            n_row_vld[r_pblk] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
        end else begin
            r_row_vld <= n_row_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.lat_row) begin
            r_row <= row_now;
        end
        if (i_cmd.cnt_clr) begin
            r_cnt <= '0;
        end else if (i_cmd.cnt_inc) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    always_comb begin
        unique case (i_cmd.asel)
            AS_PAGE: addr_sel = ADDR_W'(page_of(r_pblk, r_off));
            AS_SRC:  addr_sel = ADDR_W'(page_of(r_pblk, r_cnt));
            AS_DST:  addr_sel = ADDR_W'(page_of(r_fblk, r_cnt));
            AS_BLK:  addr_sel = ADDR_W'(r_pblk);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_out_cmd  <= i_cmd.fcmd;
            r_out_addr <= addr_sel;
            r_out_last <= i_cmd.last;
        end
    end

    assign o_out.valid         = r_out_vld;
    assign o_out.flash_command = r_out_cmd;
    assign o_out.flash_address = r_out_addr;
    assign o_out.last          = r_out_last;

    assign o_sts.req_valid  = i_req.valid;
    assign o_sts.op_wr      = r_op;
    assign o_sts.in_range   = r_rng;
    assign o_sts.pg_written = row_now[r_off];
    assign o_sts.at_off     = (r_cnt == r_off);
    assign o_sts.at_end     = (r_cnt == OF_W'(PAGES_PER_BLK - 1));
    assign o_sts.out_free   = !r_out_vld || o_out.ready;

endmodule

### hw/rtl/bmft_checker.sv
module bmft_checker import bmft_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_req_valid,
    input logic              i_req_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [1:0]        i_out_cmd,
    input logic [ADDR_W-1:0] i_out_addr,
    input logic              i_out_last
);

    // a held command keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_cmd) && $stable(i_out_addr) && $stable(i_out_last))
        else $error("command changed while stalled");

    // one request at a time
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request taken while busy");

    // erase closes a request
    a_erase_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_cmd == FC_ERASE |-> i_out_last)
        else $error("erase without last");

    // a copy program is never the final command
    a_copy_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_cmd == FC_PROG_COPY |-> !i_out_last)
        else $error("copy program marked last");

endmodule

bind block_mapping_flash_translation bmft_checker u_bmft_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_out_valid (o_cmd.valid),
    .i_out_ready (o_cmd.ready),
    .i_out_cmd   (o_cmd.flash_command),
    .i_out_addr  (o_cmd.flash_address),
    .i_out_last  (o_cmd.last)
);
